FILE: sv/assert_macros.svh
//------------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms for the checker files
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/srq_pkg.sv
//------------------------------------------------------------------------------
// srq_pkg
// types and constants of the shift register insertion queue
//------------------------------------------------------------------------------
package srq_pkg;

    localparam int CAPACITY = 16;
    localparam int POS_W    = 4;
    localparam int ID_W     = 64;
    localparam int NAME_W   = 64;
    localparam int SCORE_W  = 32;
    localparam int OCC_W    = 5;
    localparam int CNT_MIN  = $clog2(CAPACITY + 1);
    localparam int CNT_W    = (CNT_MIN > OCC_W) ? CNT_MIN : OCC_W;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [1:0] {
        MODE_ENQ = 2'd0,
        MODE_DEQ = 2'd1,
        MODE_INS = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [NAME_W-1:0]  name;
        logic [SCORE_W-1:0] score;
    } t_entry;

endpackage

FILE: sv/shift_register_insertion_queue.sv
//------------------------------------------------------------------------------
// shift_register_insertion_queue
// queue of id, name and score entries packed from slot 0, with enqueue,
// dequeue and insert at a position
//------------------------------------------------------------------------------
// input channel: i_in_valid / o_in_ready carry mode, position and the entry.
// mode enqueue appends at the tail, dequeue removes the head, insert places
// the entry at the position (at or past the count it appends).
// output channel: o_out_valid / i_out_ready carry one result per input
// transfer: status, the dequeued entry (zero otherwise), occupancy and the
// empty and full flags after the operation.
// the result is registered and valid in the cycle after the input transfer.
// throughput: one item per cycle unless stalled; every slot shifts or holds
// in parallel, so the slot update and the result register fill in the same
// cycle. a pending result does not block input while it is taken in that
// cycle; when the receiver stalls, the result holds and o_in_ready drops.
// reset (synchronous, active low) empties the queue and clears o_out_valid;
// slot contents are not cleared and are never read before being written.
// a full queue drops enqueue and insert items, an empty queue ignores dequeue.
//------------------------------------------------------------------------------
module shift_register_insertion_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_mode,
    input  logic [srq_pkg::POS_W-1:0]    i_position,
    input  logic [srq_pkg::ID_W-1:0]     i_entry_id,
    input  logic [srq_pkg::NAME_W-1:0]   i_entry_name,
    input  logic [srq_pkg::SCORE_W-1:0]  i_entry_score,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_status,
    output logic [srq_pkg::ID_W-1:0]     o_out_id,
    output logic [srq_pkg::NAME_W-1:0]   o_out_name,
    output logic [srq_pkg::SCORE_W-1:0]  o_out_score,
    output logic [srq_pkg::OCC_W-1:0]    o_occupancy,
    output logic                         o_is_empty,
    output logic                         o_is_full
);
    import srq_pkg::*;

    t_entry  r_slot [CAPACITY];
    t_entry  n_slot [CAPACITY];
    t_entry  w_prev [CAPACITY];
    t_entry  w_next [CAPACITY];
    t_entry  w_in;
    t_cnt    r_count;
    t_cnt    n_count;
    t_cnt    w_pos;
    t_cnt    w_place;
    logic    w_accept;
    logic    w_full;
    logic    w_empty;
    logic    w_tail;
    logic    r_out_valid;
    t_status r_status;
    t_status n_status;
    t_entry  r_out;
    t_entry  n_out;
    logic [OCC_W-1:0] r_occ;
    logic    r_is_empty;
    logic    r_is_full;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_in    = '{id: i_entry_id, name: i_entry_name, score: i_entry_score};
    assign w_full  = (r_count >= t_cnt'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_pos   = t_cnt'(i_position);
    assign w_tail  = (i_mode == MODE_ENQ) || (w_pos >= r_count);
    assign w_place = w_tail ? r_count : w_pos;

    // neighbor taps for the back and forward shifts
    for (genvar k = 0; k < CAPACITY; k++) begin : g_tap
        if (k == 0) begin : g_first
            assign w_prev[k] = w_in;
        end else begin : g_rest
            assign w_prev[k] = r_slot[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_next[k] = r_slot[k];
        end else begin : g_body
            assign w_next[k] = r_slot[k+1];
        end
    end

    always_comb begin
        n_slot   = r_slot;
        n_count  = r_count;
        n_status = ST_DONE;
        n_out    = '0;
        unique case (i_mode)
            MODE_ENQ, MODE_INS: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    for (int k = 0; k < CAPACITY; k++) begin
                        if (t_cnt'(k) == w_place) begin
                            n_slot[k] = w_in;
                        end else if (t_cnt'(k) > w_place && t_cnt'(k) <= r_count) begin
                            n_slot[k] = w_prev[k];
                        end
                    end
                    n_count = r_count + t_cnt'(1);
                end
            end
            MODE_DEQ: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_out   = r_slot[0];
                    n_slot  = w_next;
                    n_count = r_count - t_cnt'(1);
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_slot     <= n_slot;
            r_status   <= n_status;
            r_out      <= n_out;
            r_occ      <= n_count[OCC_W-1:0];
            r_is_empty <= (n_count == '0);
            r_is_full  <= (n_count == t_cnt'(CAPACITY));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_id    = r_out.id;
    assign o_out_name  = r_out.name;
    assign o_out_score = r_out.score;
    assign o_occupancy = r_occ;
    assign o_is_empty  = r_is_empty;
    assign o_is_full   = r_is_full;

endmodule

FILE: sv/srq_checker.sv
//------------------------------------------------------------------------------
// srq_checker
// port level checks of the shift register insertion queue
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module srq_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [1:0]                   o_status,
    input logic [srq_pkg::ID_W-1:0]     o_out_id,
    input logic [srq_pkg::OCC_W-1:0]    o_occupancy,
    input logic                         o_is_empty,
    input logic                         o_is_full
);
    import srq_pkg::*;

    // no result right after reset
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // stalled result holds
    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) && $stable(o_occupancy) && $stable(o_out_id), "stalled result changed")

    // no new transfer over a stalled result
    `ASSERT_CLK(a_no_overrun, i_clk, i_rst_n, o_out_valid && !i_out_ready |-> !o_in_ready, "input taken over stalled result")

    // empty flag follows occupancy
    `ASSERT_CLK(a_empty_flag, i_clk, i_rst_n, o_out_valid |-> (o_is_empty == (o_occupancy == '0)), "empty flag mismatch")

    // a dropped item means the queue is full, an ignored dequeue means empty
    `ASSERT_CLK(a_status_flags, i_clk, i_rst_n, o_out_valid |-> (o_status != ST_FULL || o_is_full) && (o_status != ST_EMPTY || o_is_empty), "status disagrees with flags")

endmodule

bind shift_register_insertion_queue srq_checker u_srq_checker (.*);
